[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk, quiet while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/mag_otp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mag_otp_pkg
// Widths, constants and register indexes of the magnetometer compensation.
// ----------------------------------------------------------------------------
package mag_otp_pkg;

	localparam int RAW_W   = 16;
	localparam int FIELD_W = 16;
	localparam int CFG_W   = 8;
	localparam int IDX_W   = 1;

	// register indexes
	localparam logic [IDX_W-1:0] REG_TRIM_LOW  = 1'b0;
	localparam logic [IDX_W-1:0] REG_TRIM_HIGH = 1'b1;

	// axis term: (raw - 32768) * 1000 / 1024
	localparam int TERM_MUL_W = 26;
	localparam int TERM_SHIFT = 10;
	localparam logic signed [TERM_MUL_W-1:0] TERM_SCALE = 26'sd1000;
	localparam logic signed [TERM_MUL_W-1:0] TERM_BIAS  = 26'sd1023;

	// gains
	localparam int YGAIN_W = 11;   // 814..1186
	localparam int ZGAIN_W = 14;   // 10989..16011
	localparam logic signed [11:0] YGAIN_BASE = 12'sd1000;
	localparam logic signed [11:0] YGAIN_STEP = 12'sd6;
	localparam logic signed [14:0] ZGAIN_BASE = 15'sd13500;
	localparam logic signed [14:0] ZGAIN_STEP = 15'sd81;

	// products and magnitudes
	localparam int PY_W  = 27;
	localparam int PZ_W  = 30;
	localparam int MY_W  = 26;
	localparam int MZ_W  = 29;

	// exact reciprocals: floor(m / d) = (m * R) >> K for m below 2^M_W
	localparam int RY_W = 27;
	localparam int RZ_W = 30;
	localparam int KY   = 36;
	localparam int KZ   = 43;
	localparam logic [RY_W-1:0] RECIP_Y = 27'd68719477;   // ceil(2^36 / 1000)
	localparam logic [RZ_W-1:0] RECIP_Z = 30'd879609303;  // ceil(2^43 / 10000)
	localparam int Q_W = 16;

	localparam logic signed [FIELD_W-1:0] SAT_MAX = 16'sh7fff;
	localparam logic signed [FIELD_W-1:0] SAT_MIN = 16'sh8000;

endpackage

[hw/rtl/magnetometer_otp_compensation.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// magnetometer_otp_compensation
// Raw three-axis sample to trimmed, saturated milligauss field values.
// ----------------------------------------------------------------------------
//  channel   | handshake                  | payload
//  ----------+----------------------------+-----------------------------
//  sample    | sample_valid / sample_stall| raw_x, raw_y, raw_z
//  field     | field_valid / field_stall  | field_x, field_y, field_z
//  config    | cfg_we                     | cfg_index, cfg_data
//
//  One item per cycle while sample_stall is low; six register stages. The
//  constant-reciprocal multipliers of stage five set the stage depth.
//  Reset clears all stage valid bits and both trim bytes (trims of zero).
//  A stall fills empty stages first; sample_stall rises only when all
//  six stages hold an item.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module magnetometer_otp_compensation (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  sample_valid,
	output logic                                  sample_stall,
	input  logic [mag_otp_pkg::RAW_W-1:0]         raw_x,
	input  logic [mag_otp_pkg::RAW_W-1:0]         raw_y,
	input  logic [mag_otp_pkg::RAW_W-1:0]         raw_z,
	output logic                                  field_valid,
	input  logic                                  field_stall,
	output logic signed [mag_otp_pkg::FIELD_W-1:0] field_x,
	output logic signed [mag_otp_pkg::FIELD_W-1:0] field_y,
	output logic signed [mag_otp_pkg::FIELD_W-1:0] field_z,
	input  logic                                  cfg_we,
	input  logic [mag_otp_pkg::IDX_W-1:0]         cfg_index,
	input  logic [mag_otp_pkg::CFG_W-1:0]         cfg_data
);

	localparam int FW = mag_otp_pkg::FIELD_W;

	// (raw - 32768) * 1000 / 1024, truncating toward zero
	function automatic logic signed [FW-1:0] axis_term(
			input logic [mag_otp_pkg::RAW_W-1:0] raw);
		logic signed [FW-1:0] d;
		logic signed [mag_otp_pkg::TERM_MUL_W-1:0] p;
		logic signed [mag_otp_pkg::TERM_MUL_W-1:0] pb;
		d  = $signed({~raw[mag_otp_pkg::RAW_W-1], raw[mag_otp_pkg::RAW_W-2:0]});
		p  = mag_otp_pkg::TERM_MUL_W'(d) * mag_otp_pkg::TERM_SCALE;
		pb = p[mag_otp_pkg::TERM_MUL_W-1] ? (p + mag_otp_pkg::TERM_BIAS) : p;
		return pb[mag_otp_pkg::TERM_SHIFT +: FW];
	endfunction

	function automatic logic signed [FW-1:0] sat17(input logic signed [FW:0] v);
		logic signed [FW:0] hi;
		logic signed [FW:0] lo;
		hi = (FW+1)'(mag_otp_pkg::SAT_MAX);
		lo = (FW+1)'(mag_otp_pkg::SAT_MIN);
		if (v > hi) begin
			return mag_otp_pkg::SAT_MAX;
		end else if (v < lo) begin
			return mag_otp_pkg::SAT_MIN;
		end
		return v[FW-1:0];
	endfunction

	// 6-bit trim code: c below 32 gives c, else 32 - c
	function automatic logic signed [6:0] decode_trim(input logic [5:0] c);
		logic signed [6:0] m;
		m = $signed({2'b00, c[4:0]});
		return c[5] ? -m : m;
	endfunction

	// configuration
	logic [mag_otp_pkg::CFG_W-1:0] trim_low_q;
	logic [mag_otp_pkg::CFG_W-1:0] trim_high_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trim_low_q  <= '0;
			trim_high_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				mag_otp_pkg::REG_TRIM_LOW:  trim_low_q  <= cfg_data;
				mag_otp_pkg::REG_TRIM_HIGH: trim_high_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic signed [6:0]  y_trim;
	logic signed [6:0]  z_trim;
	logic signed [11:0] y_gain;
	logic signed [14:0] z_gain;

	assign y_trim = decode_trim(trim_low_q[5:0]);
	assign z_trim = decode_trim({trim_high_q[3:0], trim_low_q[7:6]});
	assign y_gain = mag_otp_pkg::YGAIN_BASE + mag_otp_pkg::YGAIN_STEP * 12'(y_trim);
	assign z_gain = mag_otp_pkg::ZGAIN_BASE + mag_otp_pkg::ZGAIN_STEP * 15'(z_trim);

	// flow control: a stage moves when it is empty or the next one moves
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic en1, en2, en3, en4, en5, en6;

	assign en6 = !vld_s6 || !field_stall;
	assign en5 = !vld_s5 || en6;
	assign en4 = !vld_s4 || en5;
	assign en3 = !vld_s3 || en4;
	assign en2 = !vld_s2 || en3;
	assign en1 = !vld_s1 || en2;
	assign sample_stall = !en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			if (en1) vld_s1 <= sample_valid;
			if (en2) vld_s2 <= vld_s1;
			if (en3) vld_s3 <= vld_s2;
			if (en4) vld_s4 <= vld_s3;
			if (en5) vld_s5 <= vld_s4;
			if (en6) vld_s6 <= vld_s5;
		end
	end

	// stage 1: axis terms
	logic signed [FW-1:0] tx_s1, ty_s1, tz_s1;
	// stage 2: saturated difference and sum, gains
	logic signed [FW-1:0] tx_s2, diff_s2, sum_s2;
	logic [mag_otp_pkg::YGAIN_W-1:0] y_gain_s2;
	logic [mag_otp_pkg::ZGAIN_W-1:0] z_gain_s2;
	// stage 3: gain products
	logic signed [FW-1:0] tx_s3;
	logic signed [mag_otp_pkg::PY_W-1:0] py_s3;
	logic signed [mag_otp_pkg::PZ_W-1:0] pz_s3;
	// stage 4: sign and magnitude
	logic signed [FW-1:0] tx_s4;
	logic ny_s4, nz_s4;
	logic [mag_otp_pkg::MY_W-1:0] my_s4;
	logic [mag_otp_pkg::MZ_W-1:0] mz_s4;
	// stage 5: quotient magnitudes
	logic signed [FW-1:0] tx_s5;
	logic ny_s5, nz_s5;
	logic [mag_otp_pkg::Q_W-1:0] qy_s5, qz_s5;
	// stage 6: output
	logic signed [FW-1:0] field_x_s6, field_y_s6, field_z_s6;

	logic signed [FW:0] diff_w, sum_w;
	logic signed [mag_otp_pkg::PY_W-1:0] py_w;
	logic signed [mag_otp_pkg::PZ_W-1:0] pz_w;
	logic signed [mag_otp_pkg::PY_W-1:0] py_abs;
	logic signed [mag_otp_pkg::PZ_W-1:0] pz_abs;
	logic [mag_otp_pkg::MY_W+mag_otp_pkg::RY_W-1:0] qy_full;
	logic [mag_otp_pkg::MZ_W+mag_otp_pkg::RZ_W-1:0] qz_full;
	logic signed [FW:0] fy_w, fz_w;

	assign diff_w = (FW+1)'(ty_s1) - (FW+1)'(tz_s1);
	assign sum_w  = (FW+1)'(ty_s1) + (FW+1)'(tz_s1);
	assign py_w   = mag_otp_pkg::PY_W'(diff_s2)
		* mag_otp_pkg::PY_W'($signed({1'b0, y_gain_s2}));
	assign pz_w   = mag_otp_pkg::PZ_W'(sum_s2)
		* mag_otp_pkg::PZ_W'($signed({1'b0, z_gain_s2}));
	assign py_abs = py_s3[mag_otp_pkg::PY_W-1] ? -py_s3 : py_s3;
	assign pz_abs = pz_s3[mag_otp_pkg::PZ_W-1] ? -pz_s3 : pz_s3;
	assign qy_full = (mag_otp_pkg::MY_W+mag_otp_pkg::RY_W)'(my_s4)
		* (mag_otp_pkg::MY_W+mag_otp_pkg::RY_W)'(mag_otp_pkg::RECIP_Y);
	assign qz_full = (mag_otp_pkg::MZ_W+mag_otp_pkg::RZ_W)'(mz_s4)
		* (mag_otp_pkg::MZ_W+mag_otp_pkg::RZ_W)'(mag_otp_pkg::RECIP_Z);
	assign fy_w = ny_s5 ? -$signed({1'b0, qy_s5}) : $signed({1'b0, qy_s5});
	assign fz_w = nz_s5 ? -$signed({1'b0, qz_s5}) : $signed({1'b0, qz_s5});

	always_ff @(posedge clk) begin
		if (en1) begin
			tx_s1 <= axis_term(raw_x);
			ty_s1 <= axis_term(raw_y);
			tz_s1 <= axis_term(raw_z);
		end
		if (en2) begin
			tx_s2     <= tx_s1;
			diff_s2   <= sat17(diff_w);
			sum_s2    <= sat17(sum_w);
			y_gain_s2 <= y_gain[mag_otp_pkg::YGAIN_W-1:0];
			z_gain_s2 <= z_gain[mag_otp_pkg::ZGAIN_W-1:0];
		end
		if (en3) begin
			tx_s3 <= tx_s2;
			py_s3 <= py_w;
			pz_s3 <= pz_w;
		end
		if (en4) begin
			tx_s4 <= tx_s3;
			ny_s4 <= py_s3[mag_otp_pkg::PY_W-1];
			nz_s4 <= pz_s3[mag_otp_pkg::PZ_W-1];
			my_s4 <= py_abs[mag_otp_pkg::MY_W-1:0];
			mz_s4 <= pz_abs[mag_otp_pkg::MZ_W-1:0];
		end
		if (en5) begin
			tx_s5 <= tx_s4;
			ny_s5 <= ny_s4;
			nz_s5 <= nz_s4;
			qy_s5 <= qy_full[mag_otp_pkg::KY +: mag_otp_pkg::Q_W];
			qz_s5 <= qz_full[mag_otp_pkg::KZ +: mag_otp_pkg::Q_W];
		end
		if (en6) begin
			field_x_s6 <= tx_s5;
			field_y_s6 <= sat17(fy_w);
			field_z_s6 <= sat17(fz_w);
		end
	end

	assign field_valid = vld_s6;
	assign field_x     = field_x_s6;
	assign field_y     = field_y_s6;
	assign field_z     = field_z_s6;

	logic all_full;
	logic x_in_range;
	logic trim_zero;
	logic gain_base;

	assign all_full   = vld_s1 && vld_s2 && vld_s3 && vld_s4 && vld_s5 && vld_s6;
	assign x_in_range = (field_x >= -16'sd32000) && (field_x <= 16'sd31999);
	assign trim_zero  = (trim_low_q == '0) && (trim_high_q[3:0] == 4'd0);
	assign gain_base  = (y_gain == mag_otp_pkg::YGAIN_BASE)
		&& (z_gain == mag_otp_pkg::ZGAIN_BASE);

	`ASSERT_SAME(a_stall_full, sample_stall, all_full, "input stalled with an empty stage")
	`ASSERT_NEXT(a_s5_to_out, vld_s5 && en6, field_valid, "item lost at output stage")
	`ASSERT_SAME(a_x_range, field_valid, x_in_range, "X term out of range")
	`ASSERT_SAME(a_zero_trim, trim_zero, gain_base, "zero trim gives wrong gain")

endmodule

[verif/tb_magnetometer_otp_compensation.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_magnetometer_otp_compensation
// Self-checking bench: drives raw three-axis samples through the valid/stall
// channel, predicts every trimmed, saturated field item in a scoreboard and
// checks the results in order, across several trim settings and idle mixes.
// ----------------------------------------------------------------------------
module tb_magnetometer_otp_compensation;

	localparam int RAW_W   = mag_otp_pkg::RAW_W;
	localparam int FIELD_W = mag_otp_pkg::FIELD_W;
	localparam int CFG_W   = mag_otp_pkg::CFG_W;
	localparam int IDX_W   = mag_otp_pkg::IDX_W;

	localparam int PIPE_DEPTH   = 6;
	localparam int PHASE_ITEMS  = 60;
	localparam int NUM_PHASES   = 8;

	typedef struct {
		logic signed [FIELD_W-1:0] x;
		logic signed [FIELD_W-1:0] y;
		logic signed [FIELD_W-1:0] z;
	} field_t;

	// expected field items, predicted from raw samples and the current trims
	class field_scoreboard;
		field_t           field_q[$];
		logic [CFG_W-1:0] trim_low;
		logic [CFG_W-1:0] trim_high;
		int               errors;

		function new();
			trim_low  = '0;
			trim_high = '0;
			errors    = 0;
		endfunction

		function void set_trim(logic [CFG_W-1:0] lo, logic [CFG_W-1:0] hi);
			trim_low  = lo;
			trim_high = hi;
		endfunction

		function longint clamp16(longint v);
			if (v > 32767)
				return 32767;
			if (v < -32768)
				return -32768;
			return v;
		endfunction

		// (raw - 32768) * 1000 / 1024, truncating toward zero
		function longint axis_mg(logic [RAW_W-1:0] raw);
			longint d;
			d = longint'(raw) - 32768;
			return (d * 1000) / 1024;
		endfunction

		function longint trim_val(logic [5:0] code);
			longint c;
			c = longint'(code);
			if (c >= 32)
				return 32 - c;
			return c;
		endfunction

		function field_t compensate(logic [RAW_W-1:0] rx, logic [RAW_W-1:0] ry,
				logic [RAW_W-1:0] rz);
			field_t f;
			longint tx, ty, tz, y_gain, z_gain, diff, sum;
			tx     = axis_mg(rx);
			ty     = axis_mg(ry);
			tz     = axis_mg(rz);
			y_gain = 1000 + 6 * trim_val(trim_low[5:0]);
			z_gain = 13500 + 81 * trim_val({trim_high[3:0], trim_low[7:6]});
			diff   = clamp16(ty - tz);
			sum    = clamp16(ty + tz);
			f.x    = FIELD_W'(clamp16(tx));
			f.y    = FIELD_W'(clamp16((diff * y_gain) / 1000));
			f.z    = FIELD_W'(clamp16((sum * z_gain) / 10000));
			return f;
		endfunction

		function void note_sample(logic [RAW_W-1:0] rx, logic [RAW_W-1:0] ry,
				logic [RAW_W-1:0] rz);
			field_q.push_back(compensate(rx, ry, rz));
		endfunction

		function void check_field(logic signed [FIELD_W-1:0] fx,
				logic signed [FIELD_W-1:0] fy, logic signed [FIELD_W-1:0] fz);
			field_t e;
			if (field_q.size() == 0) begin
				$display("%0t: unexpected field item x=%0d y=%0d z=%0d",
					$time, fx, fy, fz);
				errors++;
				return;
			end
			e = field_q.pop_front();
			if (fx !== e.x) begin
				$display("%0t: field_x expected %0d actual %0d", $time, e.x, fx);
				errors++;
			end
			if (fy !== e.y) begin
				$display("%0t: field_y expected %0d actual %0d", $time, e.y, fy);
				errors++;
			end
			if (fz !== e.z) begin
				$display("%0t: field_z expected %0d actual %0d", $time, e.z, fz);
				errors++;
			end
		endfunction

		function int pending();
			return field_q.size();
		endfunction
	endclass

	logic                       clk;
	logic                       arst_n;
	logic                       sample_valid;
	logic                       sample_stall;
	logic [RAW_W-1:0]           raw_x;
	logic [RAW_W-1:0]           raw_y;
	logic [RAW_W-1:0]           raw_z;
	logic                       field_valid;
	logic                       field_stall;
	logic signed [FIELD_W-1:0]  field_x;
	logic signed [FIELD_W-1:0]  field_y;
	logic signed [FIELD_W-1:0]  field_z;
	logic                       cfg_we;
	logic [IDX_W-1:0]           cfg_index;
	logic [CFG_W-1:0]           cfg_data;

	field_scoreboard sb = new();
	int gap_pct   = 0;
	int stall_pct = 0;

	magnetometer_otp_compensation u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.raw_x        (raw_x),
		.raw_y        (raw_y),
		.raw_z        (raw_z),
		.field_valid  (field_valid),
		.field_stall  (field_stall),
		.field_x      (field_x),
		.field_y      (field_y),
		.field_z      (field_z),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("** magnetometer_otp_compensation: FAILED **");
		$finish;
	end

	// field side: check accepted items, stall at the current rate
	initial begin
		field_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && field_valid && !field_stall)
				sb.check_field(field_x, field_y, field_z);
			field_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
		end
	end

	task automatic send_sample(logic [RAW_W-1:0] rx, logic [RAW_W-1:0] ry,
			logic [RAW_W-1:0] rz);
		while ($urandom_range(99) < gap_pct) begin
			sample_valid <= 1'b0;
			@(posedge clk);
		end
		sample_valid <= 1'b1;
		raw_x        <= rx;
		raw_y        <= ry;
		raw_z        <= rz;
		@(posedge clk);
		while (sample_stall)
			@(posedge clk);
		sb.note_sample(rx, ry, rz);
	endtask

	task automatic wait_drained();
		sample_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	task automatic write_trims(logic [CFG_W-1:0] lo, logic [CFG_W-1:0] hi);
		cfg_we    <= 1'b1;
		cfg_index <= mag_otp_pkg::REG_TRIM_LOW;
		cfg_data  <= lo;
		@(posedge clk);
		cfg_index <= mag_otp_pkg::REG_TRIM_HIGH;
		cfg_data  <= hi;
		@(posedge clk);
		cfg_we    <= 1'b0;
		sb.set_trim(lo, hi);
	endtask

	// mostly uniform, with the null point and rails mixed in
	function automatic logic [RAW_W-1:0] rand_raw();
		case ($urandom_range(15))
			0: return 16'h0000;
			1: return 16'hffff;
			2: return 16'h8000 + RAW_W'($urandom_range(2)) - 16'd1;
			default: return RAW_W'($urandom_range(65535));
		endcase
	endfunction

	logic [RAW_W-1:0] dir_x[$] = '{16'h8000, 16'h0000, 16'hffff, 16'h0000, 16'hffff,
		16'h8000, 16'h8000, 16'h7fff, 16'h7ffe, 16'h7c00, 16'h8001, 16'haaaa,
		16'h5555, 16'h0001, 16'h7fff, 16'hfffe, 16'h83ff, 16'h1234, 16'hedcb,
		16'h8400};
	logic [RAW_W-1:0] dir_y[$] = '{16'h8000, 16'h0000, 16'hffff, 16'hffff, 16'h0000,
		16'hffff, 16'h0000, 16'h7fff, 16'h7ffe, 16'h7c00, 16'h8001, 16'h5555,
		16'haaaa, 16'hfffe, 16'h8000, 16'h0001, 16'hc000, 16'h4000, 16'hf000,
		16'h7c01};
	logic [RAW_W-1:0] dir_z[$] = '{16'h8000, 16'h0000, 16'hffff, 16'h0000, 16'hffff,
		16'hffff, 16'h0000, 16'h8001, 16'h8002, 16'h8400, 16'h7fff, 16'haaaa,
		16'h5555, 16'h0001, 16'h7fff, 16'hfffe, 16'hc000, 16'h4000, 16'h1000,
		16'h83ff};

	// trims: reset values, both codes +31, both -31, both the zero alias;
	// high nibble of the high byte is don't-care and gets exercised here
	logic [CFG_W-1:0] trim_lo_set[NUM_PHASES];
	logic [CFG_W-1:0] trim_hi_set[NUM_PHASES];

	initial begin
		arst_n       <= 1'b0;
		sample_valid <= 1'b0;
		raw_x        <= '0;
		raw_y        <= '0;
		raw_z        <= '0;
		cfg_we       <= 1'b0;
		cfg_index    <= mag_otp_pkg::REG_TRIM_LOW;
		cfg_data     <= '0;

		trim_lo_set = '{8'h00, 8'hdf, 8'hff, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00};
		trim_hi_set = '{8'h00, 8'hf7, 8'h0f, 8'h08, 8'h00, 8'h00, 8'h00, 8'h00};
		for (int i = 4; i < NUM_PHASES; i++) begin
			trim_lo_set[i] = CFG_W'($urandom_range(255));
			trim_hi_set[i] = CFG_W'($urandom_range(255));
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed corners at reset trims
		for (int i = 0; i < dir_x.size(); i++)
			send_sample(dir_x[i], dir_y[i], dir_z[i]);
		wait_drained();

		for (int p = 0; p < NUM_PHASES; p++) begin
			write_trims(trim_lo_set[p], trim_hi_set[p]);
			case (p % 4)
				0: begin gap_pct = 0;  stall_pct = 0;  end
				1: begin gap_pct = 74; stall_pct = 0;  end
				2: begin gap_pct = 0;  stall_pct = 74; end
				default: begin gap_pct = 16; stall_pct = 16; end
			endcase
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				send_sample(rand_raw(), rand_raw(), rand_raw());
				// sender holds off until the pipe empties, then resumes
				if (p == 2 && n == PHASE_ITEMS / 2)
					wait_drained();
			end
			wait_drained();
		end

		repeat (PIPE_DEPTH * 4) @(posedge clk);
		if (sb.errors == 0)
			$display("** magnetometer_otp_compensation: PASSED **");
		else
			$display("** magnetometer_otp_compensation: FAILED **");
		$finish;
	end

endmodule
